>>> rtl/msct_pkg.sv
// Shared types and constants for the multi-slot countdown timer.
// No dependencies; imported by the timer top level and its port checker.
package msct_pkg;

   // Request command codes
   localparam int CMD_W = 2;
   localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADD  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DEL  = 2'd2;

   // Fixed field widths
   localparam int ID_W      = 4;
   localparam int ELAPSED_W = 16;
   localparam int COUNT_W   = 32;

   // Default table depth and per-tick result cap
   localparam int SLOTS_DEF   = 16;
   localparam int MAX_RESULTS = 16;
   localparam int RES_W       = $clog2(MAX_RESULTS + 1);

   // One slot as kept in the slot memory
   typedef struct packed {
      logic               periodic;
      logic [COUNT_W-1:0] remaining;
      logic [COUNT_W-1:0] reload;
   } slot_entry_type;

endpackage

>>> rtl/multi_slot_countdown_timer.sv
// Multi-slot countdown timer: slot table in one synchronous memory, armed bits in flops.
// Depends on msct_pkg (command codes, widths, slot entry type).
//
// Add and delete requests complete without a scan. An enabled tick walks the slot memory
// one entry per cycle unless the response side stalls, with a read-modify-write (read
// into registered read data, then updated and written back from it), so after a tick is
// accepted req_ready stays low until the walk ends and the held expiry has left, and
// longer while the response side stalls. Expiry responses leave in ascending slot order
// through a one-deep hold register, so the final one of a tick can be flagged with last.
// A disabled tick or an unused command completes without a scan and with no response.
// Armed bits clear on reset, so no clearing pass is needed.
module multi_slot_countdown_timer #(
   parameter int SLOTS = msct_pkg::SLOTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic                          csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [msct_pkg::CMD_W-1:0]     req_cmd,
   input  logic [msct_pkg::ID_W-1:0]      req_timer_id,
   input  logic [msct_pkg::ELAPSED_W-1:0] req_elapsed_ms,
   input  logic [msct_pkg::COUNT_W-1:0]   req_initial_count,
   input  logic [msct_pkg::COUNT_W-1:0]   req_reload_interval,
   input  logic                          req_periodic,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [msct_pkg::ID_W-1:0]      rsp_expired_id,
   output logic                          rsp_was_one_shot,
   output logic                          rsp_last
);
   import msct_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   // Registers
   logic                 state_ff, state_in;
   logic                 run_enable_ff;
   logic [SLOTS-1:0]     armed_ff, armed_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [RES_W-1:0]     n_ff, n_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic                 proc_vld_ff, proc_vld_in;
   logic [IDX_W-1:0]     proc_idx_ff, proc_idx_in;
   logic                 pend_vld_ff, pend_vld_in;
   logic [ID_W-1:0]      pend_id_ff, pend_id_in;
   logic                 pend_one_ff, pend_one_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]      rsp_id_ff, rsp_id_in;
   logic                 rsp_one_ff, rsp_one_in;
   logic                 rsp_last_ff, rsp_last_in;

   // Slot memory
   slot_entry_type       mem [SLOTS];
   slot_entry_type       rd_data_ff;
   logic                 rd_en;
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_waddr;
   slot_entry_type       mem_wdata;

   // Decode helpers
   logic                 req_acc;
   logic [IDX_W+ID_W-1:0] req_id_ext;
   logic                 req_in_range;
   logic [IDX_W-1:0]     req_idx;
   logic [IDX_W+ID_W-1:0] proc_id_ext;
   logic [COUNT_W:0]     diff;
   logic [COUNT_W-1:0]   new_rem;
   logic                 expire;
   logic                 emit;
   logic                 out_free;
   logic                 stall;
   logic                 scan_done;

   assign req_ready        = (state_ff == ST_IDLE);
   assign req_acc          = req_valid && req_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_expired_id   = rsp_id_ff;
   assign rsp_was_one_shot = rsp_one_ff;
   assign rsp_last         = rsp_last_ff;

   // Request slot index and range check
   assign req_id_ext   = {{IDX_W{1'b0}}, req_timer_id};
   assign req_in_range = (req_id_ext < (IDX_W + ID_W)'(SLOTS));
   assign req_idx      = req_id_ext[IDX_W-1:0];

   // Countdown of the slot in the update stage, saturating at zero
   assign diff    = {1'b0, rd_data_ff.remaining} - {{(COUNT_W-ELAPSED_W+1){1'b0}}, elapsed_ff};
   assign new_rem = diff[COUNT_W] ? '0 : diff[COUNT_W-1:0];
   assign expire  = proc_vld_ff && armed_ff[proc_idx_ff] && (new_rem == '0);
   assign emit    = expire && (n_ff < RES_W'(MAX_RESULTS));

   assign proc_id_ext = {{ID_W{1'b0}}, proc_idx_ff};

   // Back-pressure: a new expiry must push the held one out
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign stall     = emit && pend_vld_ff && !out_free;
   assign scan_done = (state_ff == ST_SCAN) && (cnt_ff == CNT_W'(SLOTS)) && !proc_vld_ff;
   assign rd_en     = (state_ff == ST_SCAN) && (cnt_ff < CNT_W'(SLOTS)) && !stall;

   // Memory write port: add in idle, write-back during a scan
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = req_idx;
      mem_wdata.periodic  = req_periodic;
      mem_wdata.remaining = req_initial_count;
      mem_wdata.reload    = req_reload_interval;
      if (req_acc && (req_cmd == CMD_ADD) && req_in_range) begin
         mem_we = 1'b1;
      end else if (proc_vld_ff && !stall && armed_ff[proc_idx_ff]) begin
         mem_we    = 1'b1;
         mem_waddr = proc_idx_ff;
         mem_wdata = rd_data_ff;
         mem_wdata.remaining = (expire && rd_data_ff.periodic) ? rd_data_ff.reload : new_rem;
      end
   end

   // Next-state logic
   always_comb begin
      state_in     = state_ff;
      armed_in     = armed_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      elapsed_in   = elapsed_ff;
      proc_vld_in  = proc_vld_ff;
      proc_idx_in  = proc_idx_ff;
      pend_vld_in  = pend_vld_ff;
      pend_id_in   = pend_id_ff;
      pend_one_in  = pend_one_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_id_in    = rsp_id_ff;
      rsp_one_in   = rsp_one_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (req_cmd)
                  CMD_ADD: if (req_in_range) armed_in[req_idx] = 1'b1;
                  CMD_DEL: if (req_in_range) armed_in[req_idx] = 1'b0;
                  CMD_TICK: begin
                     if (run_enable_ff) begin
                        state_in   = ST_SCAN;
                        cnt_in     = '0;
                        n_in       = '0;
                        elapsed_in = req_elapsed_ms;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            // Issue stage
            if (!stall) begin
               proc_vld_in = rd_en;
               if (rd_en) begin
                  proc_idx_in = cnt_ff[IDX_W-1:0];
                  cnt_in      = cnt_ff + CNT_W'(1);
               end
            end
            // Update stage
            if (expire && !stall) begin
               if (!rd_data_ff.periodic) armed_in[proc_idx_ff] = 1'b0;
               if (emit) begin
                  n_in        = n_ff + RES_W'(1);
                  pend_vld_in = 1'b1;
                  pend_id_in  = proc_id_ext[ID_W-1:0];
                  pend_one_in = !rd_data_ff.periodic;
                  if (pend_vld_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_id_in    = pend_id_ff;
                     rsp_one_in   = pend_one_ff;
                     rsp_last_in  = 1'b0;
                  end
               end
            end
            // End of walk: release the held expiry as the last one
            if (scan_done) begin
               if (!pend_vld_ff) begin
                  state_in = ST_IDLE;
               end else if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_id_in    = pend_id_ff;
                  rsp_one_in   = pend_one_ff;
                  rsp_last_in  = 1'b1;
                  pend_vld_in  = 1'b0;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         run_enable_ff <= 1'b0;
         armed_ff      <= '0;
         proc_vld_ff   <= 1'b0;
         pend_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         armed_ff     <= armed_in;
         proc_vld_ff  <= proc_vld_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) run_enable_ff <= csr_wdata;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      n_ff        <= n_in;
      elapsed_ff  <= elapsed_in;
      proc_idx_ff <= proc_idx_in;
      pend_id_ff  <= pend_id_in;
      pend_one_ff <= pend_one_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_one_ff  <= rsp_one_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Slot memory, one read and one write port, registered read data
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (rd_en) rd_data_ff <= mem[cnt_ff[IDX_W-1:0]];
   end

endmodule

>>> rtl/msct_checker.sv
// Port-level checks for the multi-slot countdown timer, bound to its top level.
// Depends on msct_pkg (command codes, widths).
module msct_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [msct_pkg::CMD_W-1:0]     req_cmd,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [msct_pkg::ID_W-1:0]      rsp_expired_id,
   input logic                          rsp_was_one_shot,
   input logic                          rsp_last
);
   import msct_pkg::*;

   // A held response stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before accept");

   // A stalled response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_expired_id) && $stable(rsp_was_one_shot)
                                  && $stable(rsp_last))
      else $error("response payload changed while stalled");

   // Responses are only produced while a tick is being walked
   a_rsp_in_scan: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response appeared while idle");

   // Add, delete and unused commands do not hold the block busy
   a_short_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd != CMD_TICK) |=> req_ready)
      else $error("non-tick request held the block busy");

endmodule

bind multi_slot_countdown_timer msct_checker u_msct_checker (.*);
